FILE: sv/crc_pkg.sv
// shared types and constants for the congestion rate controller
`default_nettype none

package crc_pkg;

  localparam int RATE_W = 32;
  localparam int US_W = 24;
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 24;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int QUO_W = MUL_P_W;
  localparam int QCNT_W = $clog2(QUO_W);
  localparam int IDX_W = 2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_CEILING = 2'd0;
  localparam logic [IDX_W-1:0] REG_FLOOR = 2'd1;
  localparam logic [IDX_W-1:0] REG_START = 2'd2;

  localparam logic [RATE_W-1:0] DEF_CEILING = 32'd40000000;
  localparam logic [RATE_W-1:0] DEF_FLOOR = 32'd1000000;
  localparam logic [RATE_W-1:0] DEF_START = 32'd0;

  // bytes per interval to bits per second
  localparam logic [MUL_B_W-1:0] BIT_US_SCALE = 24'd8000000;
  // 16-bit fractions: 0.75, 0.85, 0.9
  localparam logic [MUL_B_W-1:0] FRAC_075 = 24'd49152;
  localparam logic [MUL_B_W-1:0] FRAC_085 = 24'd55706;
  localparam logic [MUL_B_W-1:0] FRAC_090 = 24'd58982;
  localparam logic [RATE_W-1:0] PROBE_MIN_STEP = 32'd500000;

  localparam logic [1:0] DEEP_MAX = 2'd3;
  localparam logic [2:0] CLEAN_MAX = 3'd7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_RATE,
    S_DIV_LOAD,
    S_DIV,
    S_EVAL,
    S_MUL_CUT,
    S_MUL_CAP,
    S_CUT
  } seq_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

`default_nettype wire

FILE: sv/crc_mul.sv
// shared registered multiplier
`default_nettype none

module crc_mul
  import crc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic [MUL_A_W-1:0] a,
  input  wire logic [MUL_B_W-1:0] b,
  output logic      [MUL_P_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule

`default_nettype wire

FILE: sv/crc_div.sv
// iterative restoring divider, one quotient bit per cycle
`default_nettype none

module crc_div
  import crc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [QUO_W-1:0]  dividend,
  input  wire logic [US_W-1:0]   divisor,
  output logic      [QUO_W-1:0]  quotient,
  output div_sts_t               sts
);

  logic [US_W-1:0]   rem;
  logic [US_W-1:0]   dvs;
  logic [QCNT_W-1:0] cnt;
  logic [US_W:0]     rem_sh;
  logic [US_W:0]     rem_sub;
  logic              fits;

  always_comb begin
    rem_sh = {rem, quotient[QUO_W-1]};
    rem_sub = rem_sh - {1'b0, dvs};
    fits = rem_sh >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sts.busy <= 1'b0;
      sts.done <= 1'b0;
      cnt <= '0;
    end else begin
      sts.done <= 1'b0;
      if (start) begin
        sts.busy <= 1'b1;
        cnt <= '0;
      end else if (sts.busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == QCNT_W'(QUO_W - 1)) begin
          sts.busy <= 1'b0;
          sts.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (sts.busy) begin
      quotient <= {quotient[QUO_W-2:0], fits};
      rem <= fits ? rem_sub[US_W-1:0] : rem_sh[US_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: sv/congestion_rate_controller_unit.sv
// aimd target bitrate controller, top level with sequencer
// usage:
//   one input beat per reporting interval on in_valid/in_stall, carrying
//   interval_us, tx_bytes, flush_count, backlog_bytes, queue_budget
//   one result beat per input on out_valid/out_stall: changed, new_target,
//   is_cut (new_target and is_cut are zero when changed is low)
//   config beats on cfg_valid/cfg_ready: cfg_index 0 ceiling, 1 floor,
//   2 start rate; a write reinitializes target and counters, index 3 ignored
// processing:
//   a zero-length interval is marked pending as its beat is taken, then
//   moves to the output register; otherwise one multiply for the bit count,
//   one divider load, the restoring divider (56 quotient bits and a done
//   strobe), the evaluation and the move into the output register; a cut adds
//   cut-factor and cap multiplies on the shared multiplier, then the cut step
//   in_stall stays high while an item is in work; one item at a time, the
//   next beat is taken in the cycle the result moves to the output register
// reset: registers return to 40 Mbit/s ceiling, 1 Mbit/s floor, start at
//   the ceiling, cooldown counter full, run counters clear
// stall: the result sits in an output register; the next item is taken
//   meanwhile, and its result waits in the sequencer until the slot frees
`default_nettype none

module congestion_rate_controller_unit
  import crc_pkg::*;
#(
  parameter int COOLDOWN_US = 750000,
  parameter int PROBE_INTERVALS = 5,
  parameter int DEEP_INTERVALS = 2
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // input channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [US_W-1:0]   interval_us,
  input  wire logic [31:0]       tx_bytes,
  input  wire logic [7:0]        flush_count,
  input  wire logic [31:0]       backlog_bytes,
  input  wire logic [31:0]       queue_budget,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   changed,
  output logic [RATE_W-1:0]      new_target,
  output logic                   is_cut,
  // config channel
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [RATE_W-1:0] cfg_data
);

  localparam logic [US_W-1:0] COOL = US_W'(COOLDOWN_US);
  localparam logic [2:0] PROBE_TH = 3'(PROBE_INTERVALS);
  localparam logic [1:0] DEEP_TH = 2'(DEEP_INTERVALS);

  seq_state_t state, state_next;

  // config registers
  logic [RATE_W-1:0] ceiling_rate, floor_rate, start_rate;
  logic [RATE_W-1:0] ceiling_next, floor_next, start_next;
  logic              cfg_hit;
  logic [RATE_W-1:0] init_floor, init_target;

  // controller state
  logic [RATE_W-1:0] target_rate;
  logic [US_W-1:0]   time_since_cut;
  logic [1:0]        deep_run;
  logic [2:0]        clean_run;

  // latched beat
  logic [US_W-1:0]   item_us;
  logic [31:0]       item_bytes;
  logic [7:0]        item_flush;
  logic [31:0]       item_queued;
  logic [31:0]       item_cap;

  // pending result
  logic              res_changed;
  logic [RATE_W-1:0] res_target;
  logic              res_cut;
  logic [RATE_W-1:0] cut_rate;

  // shared units
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  logic               div_start;
  logic [QUO_W-1:0]   measured;
  div_sts_t           div_sts;

  logic accept, out_load;

  crc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  crc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mul_p),
    .divisor  (item_us),
    .quotient (measured),
    .sts      (div_sts)
  );

  // config write decode and reinit values from the written registers
  always_comb begin
    ceiling_next = ceiling_rate;
    floor_next = floor_rate;
    start_next = start_rate;
    cfg_hit = 1'b0;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CEILING: begin
          ceiling_next = cfg_data;
          cfg_hit = 1'b1;
        end
        REG_FLOOR: begin
          floor_next = cfg_data;
          cfg_hit = 1'b1;
        end
        REG_START: begin
          start_next = cfg_data;
          cfg_hit = 1'b1;
        end
        default: ;
      endcase
    end
    init_floor = (floor_next < ceiling_next) ? floor_next : ceiling_next;
    if (start_next == '0) begin
      init_target = ceiling_next;
    end else if (start_next < init_floor) begin
      init_target = init_floor;
    end else if (start_next > ceiling_next) begin
      init_target = ceiling_next;
    end else begin
      init_target = start_next;
    end
  end

  // interval evaluation
  logic [US_W:0]     tsum;
  logic [US_W-1:0]   tsc_upd;
  logic              flushed, cap_nz, deep, busy_q;
  logic [1:0]        deep_upd;
  logic [2:0]        clean_pre, clean_inc;
  logic              cut_path, cut_blocked, quiet;
  logic [RATE_W-1:0] probe_step;
  logic [RATE_W:0]   probe_sum;
  logic [RATE_W-1:0] probe_tgt;
  logic [RATE_W-1:0] eff_floor, cap_rate, cut_a, cut_b;

  always_comb begin
    tsum = {1'b0, time_since_cut} + {1'b0, item_us};
    tsc_upd = tsum[US_W] ? '1 : tsum[US_W-1:0];
    flushed = item_flush != '0;
    cap_nz = item_cap != '0;
    deep = cap_nz && ({item_queued, 1'b0} > {1'b0, item_cap});
    busy_q = cap_nz && ({item_queued, 3'b000} > {3'b000, item_cap});
    if (!deep) begin
      deep_upd = '0;
    end else if (deep_run == DEEP_MAX) begin
      deep_upd = DEEP_MAX;
    end else begin
      deep_upd = deep_run + 1'b1;
    end
    clean_pre = (flushed || deep) ? '0 : clean_run;
    clean_inc = (clean_pre == CLEAN_MAX) ? CLEAN_MAX : clean_pre + 1'b1;
    cut_path = flushed || (deep_upd >= DEEP_TH);
    // link not behind, or still inside the cooldown
    cut_blocked = (tsc_upd < COOL) || (measured >= QUO_W'(target_rate));
    quiet = {measured, 1'b0} < (QUO_W + 1)'(target_rate);
    probe_step = (ceiling_rate >> 4) < PROBE_MIN_STEP ? PROBE_MIN_STEP
                                                      : ceiling_rate >> 4;
    probe_sum = {1'b0, target_rate} + {1'b0, probe_step};
    probe_tgt = (probe_sum > {1'b0, ceiling_rate}) ? ceiling_rate
                                                   : probe_sum[RATE_W-1:0];
    // cut decision; measured fits 32 bits here since it is below target
    eff_floor = (floor_rate < ceiling_rate) ? floor_rate : ceiling_rate;
    cap_rate = mul_p[47:16];
    cut_a = (flushed && measured != '0 && cap_rate < cut_rate) ? cap_rate : cut_rate;
    cut_b = (cut_a < eff_floor) ? eff_floor : cut_a;
  end

  // result waiting for the output register
  logic res_pending;

  assign accept = in_valid && !in_stall;
  assign out_load = (state == S_IDLE) && res_pending && (!out_valid || !out_stall);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && !(res_pending && !out_load)) begin
          state_next = (interval_us == '0) ? S_IDLE : S_MUL_RATE;
        end
      end
      S_MUL_RATE: state_next = S_DIV_LOAD;
      S_DIV_LOAD: state_next = S_DIV;
      S_DIV: begin
        if (div_sts.done) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: state_next = (cut_path && !cut_blocked) ? S_MUL_CUT : S_IDLE;
      S_MUL_CUT: state_next = S_MUL_CAP;
      S_MUL_CAP: state_next = S_CUT;
      S_CUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall = 1'b1;
    cfg_ready = 1'b0;
    div_start = 1'b0;
    mul_a = item_bytes;
    mul_b = BIT_US_SCALE;
    unique case (state)
      S_IDLE: begin
        // a finished result that cannot move to the output register holds off the next beat
        in_stall = res_pending && !out_load;
        cfg_ready = !res_pending;
      end
      S_DIV_LOAD: div_start = 1'b1;
      S_MUL_CUT: begin
        mul_a = target_rate;
        mul_b = flushed ? FRAC_075 : FRAC_085;
      end
      S_MUL_CAP: begin
        mul_a = measured[MUL_A_W-1:0];
        mul_b = FRAC_090;
      end
      default: ;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      res_pending <= 1'b0;
      ceiling_rate <= DEF_CEILING;
      floor_rate <= DEF_FLOOR;
      start_rate <= DEF_START;
      target_rate <= DEF_CEILING;
      time_since_cut <= COOL;
      deep_run <= '0;
      clean_run <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        // zero interval finishes at once
        res_pending <= interval_us == '0;
      end else if (state == S_EVAL && !(cut_path && !cut_blocked)) begin
        res_pending <= 1'b1;
      end else if (state == S_CUT) begin
        res_pending <= 1'b1;
      end else if (out_load) begin
        res_pending <= 1'b0;
      end
      if (cfg_hit) begin
        ceiling_rate <= ceiling_next;
        floor_rate <= floor_next;
        start_rate <= start_next;
        target_rate <= init_target;
        time_since_cut <= COOL;
        deep_run <= '0;
        clean_run <= '0;
      end else if (state == S_EVAL) begin
        time_since_cut <= tsc_upd;
        deep_run <= deep_upd;
        priority if (cut_path || quiet) begin
          clean_run <= clean_pre;
        end else if (busy_q) begin
          clean_run <= '0;
        end else if (clean_inc < PROBE_TH) begin
          clean_run <= clean_inc;
        end else begin
          clean_run <= '0;
          if (target_rate < ceiling_rate) begin
            target_rate <= probe_tgt;
          end
        end
      end else if (state == S_CUT && cut_b < target_rate) begin
        time_since_cut <= '0;
        deep_run <= '0;
        target_rate <= cut_b;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_us <= interval_us;
      item_bytes <= tx_bytes;
      item_flush <= flush_count;
      item_queued <= backlog_bytes;
      item_cap <= queue_budget;
      res_changed <= 1'b0;
      res_target <= '0;
      res_cut <= 1'b0;
    end
    if (state == S_EVAL && !cut_path && !quiet && !busy_q && clean_inc >= PROBE_TH
        && target_rate < ceiling_rate) begin
      res_changed <= 1'b1;
      res_target <= probe_tgt;
      res_cut <= 1'b0;
    end
    if (state == S_MUL_CAP) begin
      cut_rate <= mul_p[47:16];
    end
    if (state == S_CUT && cut_b < target_rate) begin
      res_changed <= 1'b1;
      res_target <= cut_b;
      res_cut <= 1'b1;
    end
    if (out_load) begin
      changed <= res_changed;
      new_target <= res_target;
      is_cut <= res_cut;
    end
  end

  // checks
  a_target_le_ceiling: assert property (@(posedge clk) disable iff (rst)
    target_rate <= ceiling_rate)
    else $error("target above ceiling");

  a_nochange_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !changed |-> new_target == '0 && !is_cut)
    else $error("no-change beat with payload");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_sts.done |-> state == S_DIV)
    else $error("divider finished outside its wait state");

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !div_sts.busy)
    else $error("divider busy while idle");

  a_pending_not_lost: assert property (@(posedge clk) disable iff (rst)
    res_pending && state == S_IDLE && out_valid && out_stall |=> res_pending)
    else $error("pending result dropped under stall");

endmodule

`default_nettype wire
